// File: rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder checkers.
// Needs clk_i and rst_ni visible at the place of use.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define U8D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, disabled in reset.
`define U8D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

// File: rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_BAD  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  localparam logic [CpW-1:0] CpMax    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi   = 21'h00DFFF;
  localparam logic [CpW-1:0] Lim1Byte = 21'h000080;
  localparam logic [CpW-1:0] Lim2Byte = 21'h000800;
  localparam logic [CpW-1:0] Lim3Byte = 21'h010000;

  // Results caused by one input word: a run of invalid results, then an
  // optional tail result (code point, invalid or end).
  typedef struct packed {
    logic [2:0]     nbad;
    logic           tail_vld;
    kind_e          tail_kind;
    logic [CpW-1:0] cp;
  } desc_t;

endpackage

// File: rtl/utf8d_decode.sv
// Sequence state and per-word decode for the UTF-8 stream decoder.
// Depends on utf8d_pkg.
module utf8d_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                end_i,
  input  logic [7:0]          byte_i,
  output logic                push_o,
  output utf8d_pkg::desc_t    desc_o
);

  logic [utf8d_pkg::CpW-1:0] pv_q, pv_d, pv_new;
  logic [2:0]                exp_q, exp_d;
  logic [1:0]                bt_q, bt_d;
  logic                      is_cont, fresh, cp_ok;
  logic [2:0]                need;

  assign is_cont = (byte_i[7:6] == 2'b10);
  assign pv_new  = {pv_q[utf8d_pkg::CpW-7:0], byte_i[5:0]};

  always_comb begin
    priority if (pv_new < utf8d_pkg::Lim1Byte) need = 3'd1;
    else if (pv_new < utf8d_pkg::Lim2Byte)    need = 3'd2;
    else if (pv_new < utf8d_pkg::Lim3Byte)    need = 3'd3;
    else                                       need = 3'd4;
  end

  assign cp_ok = (need == exp_q)
              && !(pv_new >= utf8d_pkg::SurrLo && pv_new <= utf8d_pkg::SurrHi)
              && (pv_new <= utf8d_pkg::CpMax);

  always_comb begin
    pv_d             = pv_q;
    exp_d            = exp_q;
    bt_d             = bt_q;
    fresh            = 1'b0;
    desc_o.nbad      = 3'd0;
    desc_o.tail_vld  = 1'b0;
    desc_o.tail_kind = utf8d_pkg::KIND_CODE;
    desc_o.cp        = '0;

    if (end_i) begin
      // flush pending bytes, then mark end
      desc_o.nbad      = {1'b0, bt_q};
      desc_o.tail_vld  = 1'b1;
      desc_o.tail_kind = utf8d_pkg::KIND_END;
      pv_d  = '0;
      exp_d = 3'd0;
      bt_d  = 2'd0;
    end else if (exp_q != 3'd0 && is_cont) begin
      if (({1'b0, bt_q} + 3'd1) >= exp_q) begin
        if (cp_ok) begin
          desc_o.tail_vld = 1'b1;
          desc_o.cp       = pv_new;
        end else begin
          desc_o.nbad = exp_q;
        end
        pv_d  = '0;
        exp_d = 3'd0;
        bt_d  = 2'd0;
      end else begin
        pv_d = pv_new;
        bt_d = bt_q + 2'd1;
      end
    end else begin
      // no open sequence, or a broken one: drop taken bytes as invalid, then restart
      desc_o.nbad = {1'b0, bt_q};
      pv_d  = '0;
      exp_d = 3'd0;
      bt_d  = 2'd0;
      fresh = 1'b1;
    end

    if (fresh) begin
      priority if (byte_i < 8'h80) begin
        desc_o.tail_vld = 1'b1;
        desc_o.cp       = {13'd0, byte_i};
      end else if (byte_i < 8'hC0) begin
        desc_o.tail_vld  = 1'b1;
        desc_o.tail_kind = utf8d_pkg::KIND_BAD;
      end else if (byte_i < 8'hE0) begin
        exp_d = 3'd2;
        pv_d  = {16'd0, byte_i[4:0]};
        bt_d  = 2'd1;
      end else if (byte_i < 8'hF0) begin
        exp_d = 3'd3;
        pv_d  = {17'd0, byte_i[3:0]};
        bt_d  = 2'd1;
      end else begin
        // leads F8..FF saturate to 7 so the sequence is rejected later
        exp_d = 3'd4;
        pv_d  = byte_i[3] ? 21'd7 : {18'd0, byte_i[2:0]};
        bt_d  = 2'd1;
      end
    end
  end

  assign push_o = accept_i && (desc_o.nbad != 3'd0 || desc_o.tail_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      exp_q <= 3'd0;
      bt_q  <= 2'd0;
    end else if (accept_i) begin
      pv_q  <= pv_d;
      exp_q <= exp_d;
      bt_q  <= bt_d;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: decode, result queue and output register.
// Depends on utf8d_pkg and utf8d_decode.
//
//  channel   dir  tdata                    tuser             tlast
//  s_axis    in   [7:0] data_byte          [0] action        -
//  m_axis    out  [20:0] code_point, pad   [1:0] kind        last
//
// One byte is accepted per cycle while the two-entry result queue has room.
// A byte yields 0 to 4 results; the output register drains one per cycle
// while m_axis_tready allows it, so a byte with k results takes k transfers.
// A result goes into the result queue, then into the output register, then shows on m_axis.
// Reset clears the sequence state, the queue count and pointers and the output valid.
// Stalls on m_axis back up through the queue to s_axis_tready.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic             in_fire, push;
  utf8d_pkg::desc_t dec_desc, head;
  utf8d_pkg::desc_t fifo_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic [2:0]       idx_q, total;
  logic             load, pop, is_bad, is_last;

  logic                      out_vld_q;
  utf8d_pkg::kind_e          kind_q;
  logic [utf8d_pkg::CpW-1:0] cp_q;
  logic                      last_q;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  utf8d_decode u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .end_i    (s_axis_tuser),
    .byte_i   (s_axis_tdata),
    .push_o   (push),
    .desc_o   (dec_desc)
  );

  assign head    = fifo_q[rd_ptr_q];
  assign total   = head.nbad + {2'd0, head.tail_vld};
  assign is_bad  = (idx_q < head.nbad);
  assign is_last = (idx_q == total - 3'd1);
  assign load    = (cnt_q != 2'd0) && (!out_vld_q || m_axis_tready);
  assign pop     = load && is_last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec_desc;
    end
    if (load) begin
      kind_q <= is_bad ? utf8d_pkg::KIND_BAD : head.tail_kind;
      cp_q   <= is_bad ? '0 : head.cp;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cnt_q     <= 2'd0;
      idx_q     <= 3'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (pop) begin
        idx_q <= 3'd0;
      end else if (load) begin
        idx_q <= idx_q + 3'd1;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'd0, cp_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

// File: rtl/utf8d_chk.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8d_pkg and utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module utf8d_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic is_code;
  assign is_code = m_axis_tvalid && (m_axis_tuser == utf8d_pkg::KIND_CODE);

  `U8D_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `U8D_ASSERT_IMP(a_noncode_zero, m_axis_tvalid && !is_code, m_axis_tdata == 24'd0)
  `U8D_ASSERT_IMP(a_end_last, m_axis_tvalid && m_axis_tuser == utf8d_pkg::KIND_END, m_axis_tlast)
  `U8D_ASSERT_IMP(a_scalar, is_code, m_axis_tdata <= 24'h10FFFF && !(m_axis_tdata >= 24'hD800 && m_axis_tdata <= 24'hDFFF))

endmodule

bind utf8_stream_decoder utf8d_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_decoder: byte words in, decoded symbols out.
// Depends on utf8d_pkg and the decoder RTL. Holds its own decoding model and result queue.
module tb;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned RandomWords = 420;

  typedef struct {
    utf8d_pkg::kind_e          kind;
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      last;
  } symbol_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [20:0] code_point, [23:21] zero
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // decoder model state
  logic [utf8d_pkg::CpW-1:0] seq_value = '0;
  logic [2:0]                seq_len = '0;
  logic [1:0]                seq_taken = '0;

  symbol_t     expected_symbols[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  rx_phase = '0;
  logic [1:0]  rx_mode = '0;

  utf8_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic void push_symbol(utf8d_pkg::kind_e k, logic [utf8d_pkg::CpW-1:0] cp);
    symbol_t s;
    s.kind = k;
    s.cp   = (k == utf8d_pkg::KIND_CODE) ? cp : '0;
    s.last = 1'b0;
    expected_symbols.push_back(s);
  endfunction

  function automatic void push_bad(int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_symbol(utf8d_pkg::KIND_BAD, '0);
  endfunction

  function automatic logic scalar_legal(logic [utf8d_pkg::CpW-1:0] cp, logic [2:0] len);
    logic [2:0] need;
    need = (cp < utf8d_pkg::Lim1Byte) ? 3'd1 :
           (cp < utf8d_pkg::Lim2Byte) ? 3'd2 :
           (cp < utf8d_pkg::Lim3Byte) ? 3'd3 : 3'd4;
    return (need == len) && (cp < utf8d_pkg::SurrLo || cp > utf8d_pkg::SurrHi)
        && (cp <= utf8d_pkg::CpMax);
  endfunction

  function automatic void open_byte(logic [7:0] b);
    if (b < 8'h80) begin
      push_symbol(utf8d_pkg::KIND_CODE, {13'd0, b});
    end else if (b < 8'hC0) begin
      push_symbol(utf8d_pkg::KIND_BAD, '0);
    end else begin
      if (b < 8'hE0) begin
        seq_len   = 3'd2;
        seq_value = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        seq_len   = 3'd3;
        seq_value = {17'd0, b[3:0]};
      end else begin
        // payload of 0xF8..0xFF leads saturates to 7
        seq_len   = 3'd4;
        seq_value = b[3] ? 21'd7 : {18'd0, b[2:0]};
      end
      seq_taken = 2'd1;
    end
  endfunction

  function automatic void decode_word(logic act, logic [7:0] b);
    int unsigned base;
    symbol_t     s;
    base = expected_symbols.size();
    if (act) begin
      push_bad(seq_taken);
      seq_value = '0; seq_len = '0; seq_taken = '0;
      push_symbol(utf8d_pkg::KIND_END, '0);
    end else if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_value = {seq_value[14:0], b[5:0]};
        if (int'(seq_taken) + 1 >= int'(seq_len)) begin
          if (scalar_legal(seq_value, seq_len)) push_symbol(utf8d_pkg::KIND_CODE, seq_value);
          else push_bad(seq_len);
          seq_value = '0; seq_len = '0; seq_taken = '0;
        end else begin
          seq_taken = seq_taken + 2'd1;
        end
      end else begin
        push_bad(seq_taken);
        seq_value = '0; seq_len = '0; seq_taken = '0;
        open_byte(b);
      end
    end else begin
      open_byte(b);
    end
    if (expected_symbols.size() > base) begin
      s = expected_symbols.pop_back();
      s.last = 1'b1;
      expected_symbols.push_back(s);
    end
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_word(input logic act, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // long bursts now and then so stretches run with no idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_word(act, b);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b);
  endtask

  task automatic send_end();
    send_word(1'b1, 8'($urandom()));
  endtask

  // Send the first nbytes of the len-byte form of cp; len may exceed the
  // shortest form, which gives overlong encodings.
  task automatic send_encoded(input logic [utf8d_pkg::CpW-1:0] cp, input int unsigned len,
                              input int unsigned nbytes);
    logic [7:0] seq[4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int unsigned i = 0; i < nbytes; i++) send_byte(seq[i]);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_symbols.size() != 0);
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: a new mode is drawn whenever rx_phase[5:0] is zero
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= (rx_phase[1:0] == 2'd3);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    symbol_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_symbols.size() == 0) begin
        $error("unexpected word: kind %0d code_point %h", m_axis_tuser, m_axis_tdata[20:0]);
        mismatches++;
      end else begin
        want = expected_symbols.pop_front();
        if (m_axis_tuser != want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[20:0] != want.cp) begin
          $error("code_point: expected %h, actual %h", want.cp, m_axis_tdata[20:0]);
          mismatches++;
        end
        if (m_axis_tdata[23:21] != 3'd0) begin
          $error("pad: expected 0, actual %0d", m_axis_tdata[23:21]);
          mismatches++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_single_bytes();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);   // lone continuation
  endtask

  task automatic test_good_sequences();
    send_encoded(21'h000080, 2, 2);
    send_encoded(21'h00FFFF, 3, 3);
    send_encoded(utf8d_pkg::CpMax, 4, 4);
  endtask

  task automatic test_rejected_sequences();
    send_byte(8'hC1); send_byte(8'hBF);                    // overlong
    send_encoded(21'h00D800, 3, 3);                        // surrogate
    send_encoded(21'h110000, 4, 4);                        // above range
    send_byte(8'hFF); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
  endtask

  task automatic test_broken_and_end();
    send_byte(8'hE2); send_byte(8'h41);                    // broken by ASCII
    send_byte(8'hF0); send_byte(8'h90);
    send_end();                                            // flush two pending
    send_end();
  endtask

  task automatic send_noncont();
    if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(8'h00, 8'h7F)));
    else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
  endtask

  task automatic test_random_stream();
    int unsigned               pick;
    int unsigned               len;
    logic [utf8d_pkg::CpW-1:0] cp;
    while (words_sent < RandomWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 4);
        case (len)
          1: cp = 21'($urandom_range(0, 21'h7F));
          2: cp = 21'($urandom_range(21'h80, 21'h7FF));
          3: begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            if (cp >= utf8d_pkg::SurrLo && cp <= utf8d_pkg::SurrHi) cp = cp ^ 21'h8000;
          end
          default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        send_encoded(cp, len, len);
      end else if (pick < 50) begin
        len = $urandom_range(2, 4);
        cp = (len == 2) ? 21'($urandom_range(0, 21'h7F))
           : (len == 3) ? 21'($urandom_range(0, 21'h7FF))
           :              21'($urandom_range(0, 21'hFFFF));
        send_encoded(cp, len, len);
      end else if (pick < 56) begin
        send_encoded(21'($urandom_range(utf8d_pkg::SurrLo, utf8d_pkg::SurrHi)), 3, 3);
      end else if (pick < 62) begin
        send_encoded(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
      end else if (pick < 66) begin
        send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        repeat (3) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 78) begin
        len = $urandom_range(2, 4);
        send_encoded(21'($urandom_range(0, 21'h10FFFF)), len, $urandom_range(1, len - 1));
        send_noncont();
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom()));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(2, 4);
          send_encoded(21'($urandom_range(0, 21'h10FFFF)), len, $urandom_range(1, len - 1));
        end
        send_end();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_good_sequences();
    test_rejected_sequences();
    test_broken_and_end();
    hold_until_drained();
    test_random_stream();

    s_axis_tvalid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (expected_symbols.size() != 0) begin
      $error("%0d expected words never arrived", expected_symbols.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8_stream_decoder.sv
rtl/utf8d_chk.sv
sim/tb.sv
